@@ src/lpfp_pkg.sv @@
package lpfp_pkg;

   // Fixed frame geometry.
   localparam int HDR_BYTES = 24;
   localparam int LEN_BYTES = 4;
   localparam int HDR_W = 8 * HDR_BYTES;
   localparam int IDX_W = 5;
   localparam logic [IDX_W-1:0] LEN_LAST = IDX_W'(LEN_BYTES - 1);
   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_BYTES - 1);

   // Default payload limit and the register's width.
   localparam int MAX_PAYLOAD_DEF = 4096;
   localparam int MAX_PAYLOAD_REG_W = 13;
   localparam int BODY_LEN_W = 13;

   // Register file layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MAX_PAYLOAD = 1'b0;
   localparam logic [MAX_PAYLOAD_REG_W-1:0] MAX_PAYLOAD_RST = MAX_PAYLOAD_REG_W'(4096);

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_LEN = 2'd0,
      PH_HDR = 2'd1,
      PH_PAY = 2'd2,
      PH_ERR = 2'd3
   } phase_type;

   // Header layout in wire order, first byte at the top.
   typedef struct packed {
      logic [7:0]  version;
      logic [7:0]  msg_type;
      logic [15:0] flags;
      logic [31:0] sender;
      logic [31:0] room_id;
      logic [63:0] timestamp;
      logic [31:0] msg_ident;
   } hdr_type;

   typedef struct packed {
      kind_type                 result_kind;
      hdr_type                  hdr;
      logic [BODY_LEN_W-1:0]    body_len;
      logic [7:0]               payload_byte;
      logic                     last;
   } rsp_type;

endpackage

@@ src/lpfp_csr.sv @@
module lpfp_csr
   import lpfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   parameter int PL_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic [PL_W-1:0]       limit
);

   logic [MAX_PAYLOAD_REG_W-1:0] max_len_ff;
   logic [MAX_PAYLOAD_REG_W-1:0] max_len_in;
   logic                         wr_max_len;

   // A write lands in the access phase of the transaction.
   assign wr_max_len = psel && penable && pwrite && (paddr[2] == CSR_IDX_MAX_PAYLOAD);
   assign max_len_in = wr_max_len ? pwdata[MAX_PAYLOAD_REG_W-1:0] : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RST;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Reads return the register, other addresses read as zero.
   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_MAX_PAYLOAD) begin
         prdata = CSR_DATA_W'(max_len_ff);
      end
   end

   // The limit in use never exceeds the build-time payload maximum.
   always_comb begin
      if (32'(max_len_ff) > 32'(MAX_PAYLOAD)) begin
         limit = PL_W'(MAX_PAYLOAD);
      end else begin
         limit = PL_W'(max_len_ff);
      end
   end

endmodule

@@ src/lpfp_in_stage.sv @@
module lpfp_in_stage
   import lpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       load;

   // The stage refills in the same cycle that the core consumes it.
   assign in_ready = !valid_ff || take;
   assign load = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (take ? 1'b0 : valid_ff);
   assign byte_in = load ? in_byte : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte = byte_ff;

endmodule

@@ src/lpfp_core.sv @@
module lpfp_core
   import lpfp_pkg::*;
#(
   parameter int PL_W = 13
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  logic [7:0]      item_byte,
   input  logic            out_free,
   input  logic [PL_W-1:0] limit,
   output logic            take,
   output logic            has_result,
   output rsp_type         result
);

   phase_type              phase_ff;
   phase_type              phase_in;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       idx_in;
   logic [23:0]            len_sr_ff;
   logic [23:0]            len_sr_in;
   logic [HDR_W-9:0]       hdr_sr_ff;
   logic [HDR_W-9:0]       hdr_sr_in;
   logic [PL_W-1:0]        left_ff;
   logic [PL_W-1:0]        left_in;
   logic [31:0]            total_len;
   logic [31:0]            len_diff;
   logic                   len_ok;
   logic [HDR_W-1:0]       hdr_full;

   // Length check on the fourth length byte.
   assign total_len = {len_sr_ff, item_byte};
   assign len_diff = total_len - 32'(HDR_BYTES);
   assign len_ok = (total_len >= 32'(HDR_BYTES)) && (len_diff <= 32'(limit));
   assign hdr_full = {hdr_sr_ff, item_byte};

   // An item that yields no result never waits on the output register.
   assign take = item_valid && (!has_result || out_free);

   // Result for the byte in the input stage.
   always_comb begin
      has_result = 1'b0;
      result = '0;
      case (phase_ff)
         PH_LEN: begin
            if (idx_ff == LEN_LAST && !len_ok) begin
               has_result = 1'b1;
               result.result_kind = KIND_ERROR;
               result.last = 1'b1;
            end
         end
         PH_HDR: begin
            if (idx_ff == HDR_LAST) begin
               has_result = 1'b1;
               result.result_kind = KIND_HEADER;
               result.hdr = hdr_type'(hdr_full);
               result.body_len = BODY_LEN_W'(left_ff);
               result.last = (left_ff == '0);
            end
         end
         PH_PAY: begin
            has_result = 1'b1;
            result.result_kind = KIND_PAYLOAD;
            result.payload_byte = item_byte;
            result.last = (left_ff == PL_W'(1));
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // Next state, advanced only when the byte is consumed.
   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      len_sr_in = len_sr_ff;
      hdr_sr_in = hdr_sr_ff;
      left_in = left_ff;
      if (take) begin
         case (phase_ff)
            PH_LEN: begin
               len_sr_in = total_len[23:0];
               if (idx_ff == LEN_LAST) begin
                  idx_in = '0;
                  if (len_ok) begin
                     phase_in = PH_HDR;
                     left_in = PL_W'(len_diff);
                  end else begin
                     phase_in = PH_ERR;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_HDR: begin
               hdr_sr_in = hdr_full[HDR_W-9:0];
               if (idx_ff == HDR_LAST) begin
                  idx_in = '0;
                  phase_in = (left_ff == '0) ? PH_LEN : PH_PAY;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            PH_PAY: begin
               left_in = left_ff - PL_W'(1);
               if (left_ff == PL_W'(1)) begin
                  phase_in = PH_LEN;
               end
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         idx_ff <= '0;
         left_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      len_sr_ff <= len_sr_in;
      hdr_sr_ff <= hdr_sr_in;
   end

`ifndef ASSERT_OFF
   // Once in error, no byte produces a result.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERR) |-> !has_result)
      else $error("result produced in error phase");

   // An error result locks the parser.
   assert property (@(posedge clock) disable iff (reset)
      (take && has_result && result.result_kind == KIND_ERROR) |=> (phase_ff == PH_ERR))
      else $error("error result did not lock the parser");

   // The payload phase always has bytes left to emit.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (left_ff != '0))
      else $error("payload phase with no bytes left");

   // The length phase counts at most four bytes.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (idx_ff <= LEN_LAST))
      else $error("length byte index out of range");
`endif

endmodule

@@ src/length_prefixed_frame_parser.sv @@
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    req_data_byte (8 bits)
// rsp       out        rsp_valid/ready    kind, header fields, body length, byte, last
// csr       in         csr_psel/penable   payload limit register at byte address 0
//
// One byte is accepted per clock cycle unless the result register stalls; a
// byte passes the input stage and then the result register before its result.
// A stalled result register holds back only bytes that yield a result. Reset
// is synchronous and active high and returns the parser to the length phase
// with the limit register at 4096. A length error stays until reset.
module length_prefixed_frame_parser
   import lpfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_result_kind,
   output logic [7:0]               rsp_version,
   output logic [7:0]               rsp_msg_type,
   output logic [15:0]              rsp_flags,
   output logic [31:0]              rsp_sender,
   output logic [31:0]              rsp_room_id,
   output logic [63:0]              rsp_timestamp,
   output logic [31:0]              rsp_msg_ident,
   output logic [BODY_LEN_W-1:0]    rsp_body_len,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   localparam int LIM_MAX = (MAX_PAYLOAD < 8191) ? MAX_PAYLOAD : 8191;
   localparam int PL_W = $clog2(LIM_MAX + 1);

   logic            item_valid;
   logic [7:0]      item_byte;
   logic            take;
   logic            has_result;
   logic            out_free;
   logic [PL_W-1:0] limit;
   rsp_type         result;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_load;

   assign csr_pready = 1'b1;

   lpfp_csr #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .PL_W(PL_W)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .psel(csr_psel),
      .penable(csr_penable),
      .pwrite(csr_pwrite),
      .paddr(csr_paddr),
      .pwdata(csr_pwdata),
      .prdata(csr_prdata),
      .limit(limit)
   );

   lpfp_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_byte(req_data_byte),
      .in_ready(req_ready),
      .take(take),
      .item_valid(item_valid),
      .item_byte(item_byte)
   );

   lpfp_core #(
      .PL_W(PL_W)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .item_valid(item_valid),
      .item_byte(item_byte),
      .out_free(out_free),
      .limit(limit),
      .take(take),
      .has_result(has_result),
      .result(result)
   );

   // Result register: refilled in the cycle the previous transaction leaves.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = take && has_result;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_in = rsp_load ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_version = rsp_ff.hdr.version;
   assign rsp_msg_type = rsp_ff.hdr.msg_type;
   assign rsp_flags = rsp_ff.hdr.flags;
   assign rsp_sender = rsp_ff.hdr.sender;
   assign rsp_room_id = rsp_ff.hdr.room_id;
   assign rsp_timestamp = rsp_ff.hdr.timestamp;
   assign rsp_msg_ident = rsp_ff.hdr.msg_ident;
   assign rsp_body_len = rsp_ff.body_len;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_last = rsp_ff.last;

`ifndef ASSERT_OFF
   // A result is only loaded when the register is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

   // A waiting result is not lost when a byte without a result advances.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result dropped");

   // A byte that yields a result advances only into a free register.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid && has_result && !out_free) |-> !take)
      else $error("byte consumed while result register full");
`endif

endmodule
